### sv/hysteresis_servo_ramp_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for hysteresis_servo_ramp
// Clocked assertion helpers used by hysteresis_servo_ramp.sv to check this block.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_SERVO_RAMP_ASSERT_SVH
`define HYSTERESIS_SERVO_RAMP_ASSERT_SVH

// checked on every clk edge, off while rst_n is low
`define HSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clk edge, reset included
`define HSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Widths, register indexes, types and DAC scaling constants of the servo ramp.
// ----------------------------------------------------------------------------
package hsr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int PULSE_W     = 15;
    localparam int STEP_W      = 10;
    localparam int DAC_W       = 6;
    localparam int PERIOD_US   = 20000;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_BELOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_ABOVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_UP_TO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_ABOVE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP     = 3'd6;

    localparam logic [PULSE_W-1:0] PULSE_RESET  = 15'd500;
    localparam logic [PULSE_W-1:0] PERIOD_VAL   = PULSE_W'(PERIOD_US);

    // dac = floor(sample * 1638 / (33 * full scale)), done as a reciprocal multiply
    localparam longint DAC_NUM    = 1638;
    localparam longint DAC_DEN    = 33 * ((longint'(1) << SAMPLE_BITS) - 1);
    localparam int     DAC_SHIFT  = 24;
    localparam longint DAC_MULT_L = ((longint'(1) << DAC_SHIFT) * DAC_NUM + DAC_DEN - 1)
                                    / DAC_DEN;
    localparam int     DAC_MULT_W = $clog2(DAC_MULT_L + 1);
    localparam logic [DAC_MULT_W-1:0] DAC_MULT = DAC_MULT_W'(DAC_MULT_L);

    typedef enum logic [1:0] {
        MODE_NEUTRAL = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_CLOSE   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] open_below;
        logic [SAMPLE_BITS-1:0] neutral_above;
        logic [SAMPLE_BITS-1:0] neutral_up_to;
        logic [SAMPLE_BITS-1:0] close_above;
        logic [PULSE_W-1:0]     pulse_min_us;
        logic [PULSE_W-1:0]     pulse_max_us;
        logic [STEP_W-1:0]      ramp_step_us;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [PULSE_W-1:0] pulse_us;
        logic [PULSE_W-1:0] gap_us;
        logic [DAC_W-1:0]   dac_level;
    } result_t;

endpackage

### sv/hysteresis_servo_ramp.sv
// ----------------------------------------------------------------------------
// hysteresis_servo_ramp
// Three-zone hysteresis on an ADC sample driving a clamped servo pulse ramp.
// ----------------------------------------------------------------------------
// Each sample word stands for one servo period. The block sorts it into the
// open, neutral or close zone (samples in the gaps keep the previous mode),
// ramps the pulse width by ramp_step_us up while open and down while close,
// clamped to pulse_min_us / pulse_max_us, and returns the mode, pulse width,
// low time of the period and floor(sample*2/165) for the DAC. One sample word
// is taken per clock unless sample_stall is high (sample register full while
// the result side stalls). A sample is held in the sample register, then its
// result word in the result register. Sample register feeds the
// combinational step logic, which updates mode/pulse state and loads the
// result register in the same edge, so a sample always sees the state left by
// the one before it.
// Config writes (cfg_ready is always high) are applied at once and belong in
// idle time; an index beyond the register list is dropped.
// ----------------------------------------------------------------------------
`include "hysteresis_servo_ramp_assert.svh"

module hysteresis_servo_ramp (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [hsr_pkg::SAMPLE_BITS-1:0]     sample,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          hand_mode,
    output logic [hsr_pkg::PULSE_W-1:0]         pulse_us,
    output logic [hsr_pkg::PULSE_W-1:0]         gap_us,
    output logic [hsr_pkg::DAC_W-1:0]           dac_level,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    hsr_pkg::cfg_t                   cfg_reg;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [hsr_pkg::SAMPLE_BITS-1:0] sample_reg;
    hsr_pkg::mode_t                  mode_reg;
    logic [hsr_pkg::PULSE_W-1:0]     pulse_reg;
    logic                            result_valid_reg;
    logic                            result_valid_next;
    hsr_pkg::result_t                result_reg;
    hsr_pkg::result_t                step_res;

    logic in_accept;
    logic out_free;    // result register empty or being taken this edge
    logic advance;     // sample register moves into result register

    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || !result_stall;
    assign advance      = s1_valid_reg && out_free;
    assign sample_stall = s1_valid_reg && !out_free;
    assign in_accept    = sample_valid && !sample_stall;

    assign s1_valid_next     = in_accept || (s1_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_below    <= 12'd1365;
            cfg_reg.neutral_above <= 12'd1365;
            cfg_reg.neutral_up_to <= 12'd2730;
            cfg_reg.close_above   <= 12'd2730;
            cfg_reg.pulse_min_us  <= 15'd500;
            cfg_reg.pulse_max_us  <= 15'd2500;
            cfg_reg.ramp_step_us  <= 10'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hsr_pkg::CFG_OPEN_BELOW:
                    cfg_reg.open_below <= cfg_data[hsr_pkg::SAMPLE_BITS-1:0];
                hsr_pkg::CFG_NEUTRAL_ABOVE:
                    cfg_reg.neutral_above <= cfg_data[hsr_pkg::SAMPLE_BITS-1:0];
                hsr_pkg::CFG_NEUTRAL_UP_TO:
                    cfg_reg.neutral_up_to <= cfg_data[hsr_pkg::SAMPLE_BITS-1:0];
                hsr_pkg::CFG_CLOSE_ABOVE:
                    cfg_reg.close_above <= cfg_data[hsr_pkg::SAMPLE_BITS-1:0];
                hsr_pkg::CFG_PULSE_MIN:
                    cfg_reg.pulse_min_us <= cfg_data[hsr_pkg::PULSE_W-1:0];
                hsr_pkg::CFG_PULSE_MAX:
                    cfg_reg.pulse_max_us <= cfg_data[hsr_pkg::PULSE_W-1:0];
                hsr_pkg::CFG_RAMP_STEP:
                    cfg_reg.ramp_step_us <= cfg_data[hsr_pkg::STEP_W-1:0];
                default:
                    ;  // unmapped index, write dropped
            endcase
        end
    end

    // sample stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            sample_reg <= sample;
    end

    hsr_core u_core (
        .sample    (sample_reg),
        .mode_cur  (mode_reg),
        .pulse_cur (pulse_reg),
        .cfg       (cfg_reg),
        .res       (step_res)
    );

    // hysteresis / ramp state, updated only when a sample is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= hsr_pkg::MODE_NEUTRAL;
            pulse_reg <= hsr_pkg::PULSE_RESET;
        end
        else if (advance)
        begin
            mode_reg  <= step_res.mode;
            pulse_reg <= step_res.pulse_us;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= step_res;
    end

    assign result_valid = result_valid_reg;
    assign hand_mode    = result_reg.mode;
    assign pulse_us     = result_reg.pulse_us;
    assign gap_us       = result_reg.gap_us;
    assign dac_level    = result_reg.dac_level;

    // checks
    `HSR_ASSERT(a_stall_only_when_full, sample_stall |-> s1_valid_reg, "stall with empty stage")
    `HSR_ASSERT(a_advance_gives_result, advance |=> result_valid_reg, "consumed sample lost")
    `HSR_ASSERT(a_neutral_holds_pulse,
        (advance && step_res.mode == hsr_pkg::MODE_NEUTRAL) |=> pulse_reg == $past(pulse_reg),
        "pulse moved in neutral")
    `HSR_ASSERT(a_gap_sum,
        (result_valid_reg && result_reg.pulse_us <= hsr_pkg::PERIOD_VAL)
        |-> ({1'b0, result_reg.gap_us} + {1'b0, result_reg.pulse_us})
            == {1'b0, hsr_pkg::PERIOD_VAL},
        "gap plus pulse differs from period")
    `HSR_ASSERT(a_state_matches_result,
        advance |=> (pulse_reg == result_reg.pulse_us && mode_reg == result_reg.mode),
        "state and result out of step")

endmodule

### sv/hsr_core.sv
// ----------------------------------------------------------------------------
// hsr_core
// One servo period: zone hysteresis, pulse ramp with clamp, gap and DAC level.
// ----------------------------------------------------------------------------
module hsr_core (
    input  logic [hsr_pkg::SAMPLE_BITS-1:0] sample,
    input  hsr_pkg::mode_t                  mode_cur,
    input  logic [hsr_pkg::PULSE_W-1:0]     pulse_cur,
    input  hsr_pkg::cfg_t                   cfg,
    output hsr_pkg::result_t                res
);

    localparam int PROD_W = hsr_pkg::SAMPLE_BITS + hsr_pkg::DAC_MULT_W;

    hsr_pkg::mode_t              mode_new;
    logic [hsr_pkg::PULSE_W-1:0] pulse_new;
    logic [hsr_pkg::PULSE_W:0]   pulse_up;
    logic [hsr_pkg::PULSE_W:0]   floor_lim;
    logic [PROD_W-1:0]           dac_prod;

    // zones checked in order; a check fires only when it changes the mode
    always_comb
    begin
        mode_new = mode_cur;
        if (sample <= cfg.open_below && mode_cur != hsr_pkg::MODE_OPEN)
            mode_new = hsr_pkg::MODE_OPEN;
        else if (sample > cfg.neutral_above && sample <= cfg.neutral_up_to
                 && mode_cur != hsr_pkg::MODE_NEUTRAL)
            mode_new = hsr_pkg::MODE_NEUTRAL;
        else if (sample > cfg.close_above && mode_cur != hsr_pkg::MODE_CLOSE)
            mode_new = hsr_pkg::MODE_CLOSE;
    end

    assign pulse_up  = {1'b0, pulse_cur} + {6'b0, cfg.ramp_step_us};
    // pulse - step < min  <=>  pulse < min + step, no signed math needed
    assign floor_lim = {1'b0, cfg.pulse_min_us} + {6'b0, cfg.ramp_step_us};

    always_comb
    begin
        case (mode_new)
            hsr_pkg::MODE_CLOSE:
            begin
                if ({1'b0, pulse_cur} < floor_lim)
                    pulse_new = cfg.pulse_min_us;
                else
                    pulse_new = pulse_cur - {5'b0, cfg.ramp_step_us};
            end
            hsr_pkg::MODE_OPEN:
            begin
                if (pulse_up > {1'b0, cfg.pulse_max_us})
                    pulse_new = cfg.pulse_max_us;
                else
                    pulse_new = pulse_up[hsr_pkg::PULSE_W-1:0];
            end
            default:
                pulse_new = pulse_cur;
        endcase
    end

    assign dac_prod = PROD_W'(sample) * PROD_W'(hsr_pkg::DAC_MULT);

    always_comb
    begin
        res.mode      = mode_new;
        res.pulse_us  = pulse_new;
        res.gap_us    = (pulse_new > hsr_pkg::PERIOD_VAL) ? '0
                        : hsr_pkg::PERIOD_VAL - pulse_new;
        res.dac_level = dac_prod[hsr_pkg::DAC_SHIFT +: hsr_pkg::DAC_W];
    end

endmodule
